// ===== sv/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // classified word passed from front to back
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] na;
    logic [31:0] da;
    logic [31:0] nb;
    logic [31:0] db;
    logic        sa;
    logic        sb;
    logic        early;   // result known without arithmetic
    logic [1:0]  early_st;
  } task_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== sv/rau_front.sv =====
// ----------------------------------------------------------------------------
// rau_front
// Takes input words, forms magnitudes and signs, flags early errors.
// ----------------------------------------------------------------------------
module rau_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          mode,
  input  logic signed [31:0]  a_numerator,
  input  logic signed [31:0]  a_denominator,
  input  logic signed [31:0]  b_numerator,
  input  logic signed [31:0]  b_denominator,
  output logic                t_valid,
  input  logic                t_stall,
  output rau_pkg::task_t      t_word
);

  rau_pkg::task_t w;
  logic           full;

  always_comb begin
    w.mode = mode;
    w.na = rau_pkg::mag32(a_numerator);
    w.da = rau_pkg::mag32(a_denominator);
    w.nb = rau_pkg::mag32(b_numerator);
    w.db = rau_pkg::mag32(b_denominator);
    w.sa = (w.na != 32'd0) && (a_numerator[31] != a_denominator[31]);
    w.sb = (w.nb != 32'd0) && (b_numerator[31] != b_denominator[31]);
    w.early = 1'b0;
    w.early_st = rau_pkg::ST_OK;
    if (w.da == 32'd0 || w.db == 32'd0) begin
      w.early = 1'b1;
      w.early_st = rau_pkg::ST_ZDEN;
    end else if (mode == rau_pkg::MODE_DIV && w.nb == 32'd0) begin
      w.early = 1'b1;
      w.early_st = rau_pkg::ST_DIV0;
    end
  end

  assign in_stall = full && t_stall;
  assign t_valid  = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
    if (!in_stall && in_valid) begin
      t_word <= w;
    end
  end

endmodule

// ===== sv/rau_queue.sv =====
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module rau_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           i_valid,
  output logic           i_stall,
  input  rau_pkg::task_t i_word,
  output logic           o_valid,
  input  logic           o_stall,
  output rau_pkg::task_t o_word
);

  rau_pkg::task_t mem [2];
  logic           wp, rp;
  logic [1:0]     cnt;
  logic           push, pop;

  assign i_stall = (cnt == 2'd2);
  assign o_valid = (cnt != 2'd0);
  assign o_word  = mem[rp];
  assign push    = i_valid && !i_stall;
  assign pop     = o_valid && !o_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wp] <= i_word;
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count overflow");
  a_nopop: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) |-> !pop) else $error("pop from empty queue");
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> (wp == rp)) else $error("pointer mismatch");

endmodule

// ===== sv/rau_back.sv =====
// ----------------------------------------------------------------------------
// rau_back
// Sequencer: products, sign merge, bit-serial remainder GCD, two divisions.
// ----------------------------------------------------------------------------
module rau_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                t_valid,
  output logic                t_stall,
  input  rau_pkg::task_t      t_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  result_numerator,
  output logic [30:0]         result_denominator,
  output logic [1:0]          order,
  output logic [1:0]          status
);

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_COMB, S_GCD_INIT, S_GCD_DIV, S_GCD_STEP,
    S_QN, S_QD, S_FIN, S_OUT
  } state_t;

  state_t         st;
  rau_pkg::task_t t;
  logic [63:0]    p1, p2, num, den, x, y;
  logic           sr;
  // shared restoring divider
  logic [63:0]    dv_n, dv_d, dv_q, dv_r;
  logic [6:0]     dv_i;
  logic [64:0]    trial;
  logic [64:0]    rsh;
  logic [63:0]    d_rem, d_q;
  // sign merge and compare
  logic           s2, c_sr, c_done;
  logic [63:0]    c_num;
  logic [1:0]     c_ord;

  assign t_stall = (st != S_IDLE);
  assign rsh   = {dv_r, dv_n[63]};
  assign trial = rsh - {1'b0, dv_d};
  assign d_rem = trial[64] ? rsh[63:0] : trial[63:0];
  assign d_q   = {dv_q[62:0], !trial[64]};

  always_comb begin
    s2 = (t.mode == rau_pkg::MODE_SUB) ? (p2 != 64'd0 && !t.sb) : t.sb;
    c_num = p1;
    c_sr = t.sa != t.sb;
    c_ord = rau_pkg::ORD_EQ;
    c_done = 1'b0;
    if (t.mode == rau_pkg::MODE_ADD || t.mode == rau_pkg::MODE_SUB) begin
      if (t.sa == s2) begin
        c_num = p1 + p2;
        c_sr = t.sa;
      end else if (p1 >= p2) begin
        c_num = p1 - p2;
        c_sr = t.sa;
      end else begin
        c_num = p2 - p1;
        c_sr = s2;
      end
      c_done = (c_num == 64'd0);
    end else if (t.mode == rau_pkg::MODE_MUL || t.mode == rau_pkg::MODE_DIV) begin
      c_done = (p1 == 64'd0);
    end else begin
      c_done = 1'b1;
      if (t.sa != t.sb) c_ord = t.sa ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
      else if (p1 == p2) c_ord = rau_pkg::ORD_EQ;
      else if ((p1 < p2) != t.sa) c_ord = rau_pkg::ORD_LT;
      else c_ord = rau_pkg::ORD_GT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (t_valid) begin
            t <= t_word;
            if (t_word.early) begin
              result_numerator <= '0;
              result_denominator <= '0;
              order <= rau_pkg::ORD_EQ;
              status <= t_word.early_st;
              out_valid <= 1'b1;
              st <= S_OUT;
            end else begin
              st <= S_M1;
            end
          end
        end
        S_M1: begin
          unique case (t.mode)
            rau_pkg::MODE_MUL: p1 <= t.na * t.nb;
            default: p1 <= t.na * t.db;
          endcase
          st <= S_M2;
        end
        S_M2: begin
          unique case (t.mode)
            rau_pkg::MODE_DIV: p2 <= t.da * t.nb;
            rau_pkg::MODE_MUL: p2 <= t.da * t.db;
            default: p2 <= t.nb * t.da;
          endcase
          den <= t.da * t.db;
          st <= S_COMB;
        end
        S_COMB: begin
          result_numerator <= '0;
          result_denominator <= 31'd1;
          order <= c_ord;
          status <= rau_pkg::ST_OK;
          num <= c_num;
          sr <= c_sr;
          if (t.mode == rau_pkg::MODE_MUL || t.mode == rau_pkg::MODE_DIV) den <= p2;
          out_valid <= c_done;
          st <= c_done ? S_OUT : S_GCD_INIT;
        end
        S_GCD_INIT: begin
          x <= num; y <= den;
          st <= S_GCD_STEP;
        end
        S_GCD_STEP: begin
          if (y == 64'd0) begin
            dv_n <= num; dv_d <= x; dv_r <= '0; dv_i <= '0;
            st <= S_QN;
          end else begin
            dv_n <= x; dv_d <= y; dv_r <= '0; dv_i <= '0;
            st <= S_GCD_DIV;
          end
        end
        S_GCD_DIV, S_QN, S_QD: begin
          dv_q <= d_q;
          if (dv_i != 7'd63) begin
            dv_r <= d_rem;
            dv_n <= {dv_n[62:0], 1'b0};
            dv_i <= dv_i + 7'd1;
          end else if (st == S_GCD_DIV) begin
            x <= y;
            y <= d_rem;
            st <= S_GCD_STEP;
          end else if (st == S_QN) begin
            num <= d_q;
            dv_n <= den; dv_r <= '0; dv_i <= '0;
            st <= S_QD;
          end else begin
            den <= d_q;
            st <= S_FIN;
          end
        end
        S_FIN: begin
          if (den > 64'h7FFF_FFFF || num > (sr ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            result_numerator <= '0;
            result_denominator <= '0;
            status <= rau_pkg::ST_OVF;
          end else begin
            result_numerator <= sr ? (~num[31:0] + 32'd1) : num[31:0];
            result_denominator <= den[30:0];
            status <= rau_pkg::ST_OK;
          end
          order <= rau_pkg::ORD_EQ;
          out_valid <= 1'b1;
          st <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_ovl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (st == S_OUT)) else $error("result outside output state");
  a_den: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rau_pkg::ST_OK) |-> (result_denominator != 31'd0))
    else $error("zero denominator on ok result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational add, subtract, multiply, divide and compare with GCD reduction.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  mode, a_*, b_*
//   out      output     out_valid/out_stall result_*, order, status
//
// Zero-denominator and divide-by-zero words skip the arithmetic; compare and
// zero results leave after the products and sign merge; others run a Euclid
// GCD loop on 64-bit values, then two divisions, all on one bit-serial divider.
// Reset rst is synchronous; queue and sequencer empty after it.
// Front register and two-entry queue hold up to three words behind the back.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [31:0] a_numerator,
  input  logic signed [31:0] a_denominator,
  input  logic signed [31:0] b_numerator,
  input  logic signed [31:0] b_denominator,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_numerator,
  output logic [30:0]        result_denominator,
  output logic [1:0]         order,
  output logic [1:0]         status
);

  logic           f_valid, f_stall, q_valid, q_stall;
  rau_pkg::task_t f_word, q_word;

  rau_front u_front (
    .clk, .rst, .in_valid, .in_stall, .mode, .a_numerator, .a_denominator,
    .b_numerator, .b_denominator,
    .t_valid(f_valid), .t_stall(f_stall), .t_word(f_word)
  );

  rau_queue u_queue (
    .clk, .rst, .i_valid(f_valid), .i_stall(f_stall), .i_word(f_word),
    .o_valid(q_valid), .o_stall(q_stall), .o_word(q_word)
  );

  rau_back u_back (
    .clk, .rst, .t_valid(q_valid), .t_stall(q_stall), .t_word(q_word),
    .out_valid, .out_stall, .result_numerator, .result_denominator,
    .order, .status
  );

endmodule
